>>> sv/assert_macros.svh
// assertion macros shared by the converter rtl
// depends on nothing; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// check a property on every clock edge outside reset
`define B2D_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check a property on every clock edge, reset included
`define B2D_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define B2D_ASSERT(lbl, clk, rst_n, prop, msg)
`define B2D_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

>>> sv/b2d_pkg.sv
// constants and types for the binary to decimal ascii converter
// depends on nothing; used by the interfaces, the digit cells, the chain and the top level
package b2d_pkg;

    localparam int VALUE_BITS = 31;
    localparam int MAX_DIGITS = 10;
    localparam int DIGIT_W    = 4;
    localparam int CHAR_W     = 6;
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
    localparam int BIT_CNT_W  = $clog2(VALUE_BITS);

    localparam logic [CHAR_W-1:0]  ASCII_ZERO = CHAR_W'(48);
    localparam logic [DIGIT_W-1:0] DABBLE_MIN = DIGIT_W'(5);
    localparam logic [DIGIT_W-1:0] DABBLE_ADD = DIGIT_W'(3);

    // controller states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CONV = 4'b0010,
        ST_TRIM = 4'b0100,
        ST_EMIT = 4'b1000
    } t_state;

    // commands to the row of digit cells
    typedef struct packed {
        logic clear;
        logic dabble;
        logic shift;
    } t_chain_ctl;

endpackage

>>> sv/b2d_if.sv
// channel interfaces of the converter: integer in, ascii digit out
// depends on b2d_pkg for field widths
interface b2d_in_if;
    logic                          valid;
    logic                          ready;
    logic [b2d_pkg::VALUE_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface b2d_out_if;
    logic                       valid;
    logic                       ready;
    logic [b2d_pkg::CHAR_W-1:0] digit_char;
    logic                       last_digit;

    modport source (output valid, output digit_char, output last_digit, input ready);
    modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

>>> sv/b2d_cell.sv
// one bcd digit cell: clear, shift-and-add-3 step or whole-digit shift from its neighbor
// depends on b2d_pkg
module b2d_cell (
    input  logic                         i_clk,
    input  b2d_pkg::t_chain_ctl          i_ctl,
    input  logic                         i_bit,
    input  logic [b2d_pkg::DIGIT_W-1:0]  i_digit,
    output logic                         o_carry,
    output logic [b2d_pkg::DIGIT_W-1:0]  o_digit
);

    logic [b2d_pkg::DIGIT_W-1:0] r_digit;
    logic [b2d_pkg::DIGIT_W-1:0] n_digit;
    logic [b2d_pkg::DIGIT_W-1:0] w_adj;

    // add 3 when the digit would pass 9 after doubling
    assign w_adj   = (r_digit >= b2d_pkg::DABBLE_MIN) ? r_digit + b2d_pkg::DABBLE_ADD : r_digit;
    assign o_carry = w_adj[b2d_pkg::DIGIT_W-1];
    assign o_digit = r_digit;

    // next digit
    always_comb begin
        n_digit = r_digit;
        if (i_ctl.clear) begin
            n_digit = '0;
        end else if (i_ctl.dabble) begin
            n_digit = {w_adj[b2d_pkg::DIGIT_W-2:0], i_bit};
        end else if (i_ctl.shift) begin
            n_digit = i_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

endmodule

>>> sv/b2d_chain.sv
// row of bcd digit cells, units digit at cell 0, most significant at the far end
// depends on b2d_pkg and b2d_cell
module b2d_chain (
    input  logic                         i_clk,
    input  b2d_pkg::t_chain_ctl          i_ctl,
    input  logic                         i_bit,
    output logic [b2d_pkg::DIGIT_W-1:0]  o_top_digit,
    output logic                         o_overflow
);

    logic                        w_carry [0:b2d_pkg::MAX_DIGITS];
    logic [b2d_pkg::DIGIT_W-1:0] w_digit [0:b2d_pkg::MAX_DIGITS];

    // serial bit enters the units cell, an empty digit follows a digit shift
    assign w_carry[0] = i_bit;
    assign w_digit[0] = '0;

    for (genvar g = 0; g < b2d_pkg::MAX_DIGITS; g++) begin : g_cell
        b2d_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (i_ctl),
            .i_bit   (w_carry[g]),
            .i_digit (w_digit[g]),
            .o_carry (w_carry[g+1]),
            .o_digit (w_digit[g+1])
        );
    end

    assign o_top_digit = w_digit[b2d_pkg::MAX_DIGITS];
    assign o_overflow  = w_carry[b2d_pkg::MAX_DIGITS];

endmodule

>>> sv/binary_to_decimal_ascii.sv
// Converts one unsigned integer per transaction to its decimal text, one ASCII
// digit per output transaction, most significant digit first, with last_digit
// set on the units digit; zero gives a single '0' and no leading zeros appear.
// A row of ten BCD digit cells takes the value one bit a cycle by shift-and-add-3.
// The trim step then shifts out each leading zero digit (up to 9) and settles on
// the first digit. After that the digits leave one by one as the sink takes them,
// and sink stalls hold them back. The next number is accepted only after the units
// digit of the previous one has gone out.
// depends on b2d_pkg, b2d_if, b2d_chain and assert_macros.svh
`include "assert_macros.svh"

module binary_to_decimal_ascii (
    input  logic             i_clk,
    input  logic             i_rst_n,
    b2d_in_if.sink           i_in,
    b2d_out_if.source        o_out
);

    b2d_pkg::t_state                    r_state;
    b2d_pkg::t_state                    n_state;
    logic [b2d_pkg::VALUE_BITS-1:0]     r_value;
    logic [b2d_pkg::VALUE_BITS-1:0]     n_value;
    logic [b2d_pkg::BIT_CNT_W-1:0]      r_bit_cnt;
    logic [b2d_pkg::BIT_CNT_W-1:0]      n_bit_cnt;
    logic [b2d_pkg::CNT_W-1:0]          r_count;
    logic [b2d_pkg::CNT_W-1:0]          n_count;
    b2d_pkg::t_chain_ctl                w_ctl;
    logic [b2d_pkg::DIGIT_W-1:0]        w_top_digit;
    logic                               w_overflow;

    b2d_chain u_chain (
        .i_clk       (i_clk),
        .i_ctl       (w_ctl),
        .i_bit       (r_value[b2d_pkg::VALUE_BITS-1]),
        .o_top_digit (w_top_digit),
        .o_overflow  (w_overflow)
    );

    // handshake outputs
    assign i_in.ready       = (r_state == b2d_pkg::ST_IDLE);
    assign o_out.valid      = (r_state == b2d_pkg::ST_EMIT);
    assign o_out.digit_char = b2d_pkg::ASCII_ZERO
                            + {{(b2d_pkg::CHAR_W - b2d_pkg::DIGIT_W){1'b0}}, w_top_digit};
    assign o_out.last_digit = (r_count == b2d_pkg::CNT_W'(1));

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_value   = r_value;
        n_bit_cnt = r_bit_cnt;
        n_count   = r_count;
        w_ctl     = '0;
        case (r_state)
            b2d_pkg::ST_IDLE: begin
                if (i_in.valid) begin
                    n_value   = i_in.value;
                    n_bit_cnt = '0;
                    n_count   = b2d_pkg::CNT_W'(b2d_pkg::MAX_DIGITS);
                    w_ctl.clear = 1'b1;
                    n_state   = b2d_pkg::ST_CONV;
                end
            end
            b2d_pkg::ST_CONV: begin
                w_ctl.dabble = 1'b1;
                n_value   = {r_value[b2d_pkg::VALUE_BITS-2:0], 1'b0};
                n_bit_cnt = r_bit_cnt + b2d_pkg::BIT_CNT_W'(1);
                if (r_bit_cnt == b2d_pkg::BIT_CNT_W'(b2d_pkg::VALUE_BITS - 1)) begin
                    n_state = b2d_pkg::ST_TRIM;
                end
            end
            b2d_pkg::ST_TRIM: begin
                // drop leading zeros, keep at least the units digit
                if (w_top_digit == '0 && r_count != b2d_pkg::CNT_W'(1)) begin
                    w_ctl.shift = 1'b1;
                    n_count     = r_count - b2d_pkg::CNT_W'(1);
                end else begin
                    n_state = b2d_pkg::ST_EMIT;
                end
            end
            b2d_pkg::ST_EMIT: begin
                if (o_out.ready) begin
                    if (r_count == b2d_pkg::CNT_W'(1)) begin
                        n_state = b2d_pkg::ST_IDLE;
                    end else begin
                        w_ctl.shift = 1'b1;
                        n_count     = r_count - b2d_pkg::CNT_W'(1);
                    end
                end
            end
            default: begin
                n_state = b2d_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= b2d_pkg::ST_IDLE;
            r_bit_cnt <= '0;
            r_count   <= '0;
        end else begin
            r_state   <= n_state;
            r_bit_cnt <= n_bit_cnt;
            r_count   <= n_count;
        end
    end

    // value shift register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value <= '0;
        end else begin
            r_value <= n_value;
        end
    end

    // assertions
    `B2D_ASSERT(a_no_lead_zero, i_clk, i_rst_n, $rose(o_out.valid) |-> (w_top_digit != '0 || r_count == b2d_pkg::CNT_W'(1)), "leading zero digit emitted")
    `B2D_ASSERT(a_digit_range, i_clk, i_rst_n, o_out.valid |-> (w_top_digit <= b2d_pkg::DIGIT_W'(9)), "digit cell out of decimal range")
    `B2D_ASSERT(a_no_overflow, i_clk, i_rst_n, w_ctl.dabble |-> !w_overflow, "digit row overflow")
    `B2D_ASSERT(a_last_frees, i_clk, i_rst_n, (o_out.valid && o_out.ready && o_out.last_digit) |=> i_in.ready, "not idle after last digit")
    `B2D_ASSERT(a_count_live, i_clk, i_rst_n, (r_state != b2d_pkg::ST_IDLE) |-> (r_count != '0), "digit count empty while busy")

endmodule

>>> tb/binary_to_decimal_ascii_tb.sv
// self-checking testbench for binary_to_decimal_ascii: numbers in, ascii digits out
// a directed table, then random numbers of every length under several idling patterns
// depends on b2d_pkg, b2d_if and the binary_to_decimal_ascii rtl
`timescale 1ns / 100ps

module binary_to_decimal_ascii_tb;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 9;
    localparam int RANDOM_PER_PH = 100;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 60;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int REPORT_MAX    = 10;

    // one number to send; text holds the expected decimal string when typed in by hand
    typedef struct {
        logic [b2d_pkg::VALUE_BITS-1:0] value;
        string                          text;
    } t_number_job;

    typedef struct {
        logic [b2d_pkg::CHAR_W-1:0] digit_char;
        logic                       last_digit;
    } t_ascii_digit;

    logic i_clk = 1'b0;
    logic i_rst_n;

    b2d_in_if  in_ch ();
    b2d_out_if out_ch ();

    binary_to_decimal_ascii i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    t_number_job  send_q[$];
    t_ascii_digit expected_digits[$];
    t_number_job  offered;
    t_ascii_digit next_digit;
    t_number_job  directed_rows[19];

    int sender_idle_pct  = 0;
    int recv_stall_pct   = 0;
    int pending_numbers  = 0;
    int numbers_accepted = 0;
    int digits_checked   = 0;
    int mismatch_count   = 0;
    int cycle_count      = 0;
    int hold_left        = 0;
    bit hold_request     = 1'b0;

    // clock
    always #CLK_HALF i_clk = ~i_clk;

    // expected digits of one number, found by repeated division by ten
    function automatic void predict_digits(input logic [b2d_pkg::VALUE_BITS-1:0] value);
        logic [b2d_pkg::DIGIT_W-1:0] digits[b2d_pkg::MAX_DIGITS];
        longint unsigned             rest;
        int                          count;
        t_ascii_digit                d;
        rest  = value;
        count = 0;
        do begin
            digits[count] = b2d_pkg::DIGIT_W'(rest % 10);
            rest          = rest / 10;
            count++;
        end while (rest != 0 && count < b2d_pkg::MAX_DIGITS);
        for (int k = count - 1; k >= 0; k--) begin
            d.digit_char = b2d_pkg::ASCII_ZERO + b2d_pkg::CHAR_W'(digits[k]);
            d.last_digit = (k == 0);
            expected_digits.push_back(d);
        end
    endfunction

    // hand-typed text wins over the predictor
    function automatic void expect_number(input t_number_job job);
        t_ascii_digit d;
        if (job.text.len() == 0) begin
            predict_digits(job.value);
        end else begin
            for (int i = 0; i < job.text.len(); i++) begin
                d.digit_char = b2d_pkg::CHAR_W'(job.text[i]);
                d.last_digit = (i == job.text.len() - 1);
                expected_digits.push_back(d);
            end
        end
    endfunction

    // random number with a random digit count, sometimes a raw 31-bit pattern
    function automatic logic [b2d_pkg::VALUE_BITS-1:0] random_value();
        int unsigned     len;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned top;
        top = (64'd1 << b2d_pkg::VALUE_BITS) - 1;
        if ($urandom_range(7) == 0) begin
            return b2d_pkg::VALUE_BITS'($urandom);
        end
        len = $urandom_range(b2d_pkg::MAX_DIGITS, 1);
        lo  = 1;
        for (int i = 1; i < len; i++) begin
            lo = lo * 10;
        end
        hi = lo * 10 - 1;
        if (len == 1) begin
            lo = 0;
        end
        if (hi > top) begin
            hi = top;
        end
        return b2d_pkg::VALUE_BITS'(lo + $urandom_range(32'(hi - lo)));
    endfunction

    task automatic queue_number(input logic [b2d_pkg::VALUE_BITS-1:0] value,
                                input string text);
        t_number_job job;
        job.value = value;
        job.text  = text;
        pending_numbers++;
        send_q.push_back(job);
    endtask

    task automatic wait_drained();
        while (pending_numbers != 0 || expected_digits.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic run_phase(input int sender_pct, input int recv_pct, input int count);
        sender_idle_pct = sender_pct;
        recv_stall_pct  = recv_pct;
        for (int i = 0; i < count; i++) begin
            queue_number(random_value(), "");
        end
        wait_drained();
    endtask

    task automatic note_mismatch(input string what, input t_ascii_digit want,
                                 input t_ascii_digit got);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX) begin
            $display("mismatch (%s) at cycle %0d: expected char %0d last %b, got char %0d last %b",
                     what, cycle_count, want.digit_char, want.last_digit,
                     got.digit_char, got.last_digit);
        end
    endtask

    // number sender: holds the offer until it is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                expect_number(offered);
                numbers_accepted++;
                pending_numbers--;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (send_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    offered = send_q.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.value <= offered.value;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // digit receiver with random stalls and a single long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // compare each digit transaction with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            digits_checked++;
            if (expected_digits.size() == 0) begin
                next_digit.digit_char = 'x;
                next_digit.last_digit = 1'bx;
                note_mismatch("unexpected digit", next_digit,
                              '{out_ch.digit_char, out_ch.last_digit});
            end else begin
                next_digit = expected_digits.pop_front();
                if (out_ch.digit_char !== next_digit.digit_char ||
                    out_ch.last_digit !== next_digit.last_digit) begin
                    note_mismatch("wrong digit", next_digit,
                                  '{out_ch.digit_char, out_ch.last_digit});
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d numbers still pending",
                     cycle_count, pending_numbers);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.value  = '0;
        out_ch.ready = 1'b0;

        // zero, single digits, some power-of-ten boundaries, the top of the range
        directed_rows = '{
            '{31'd0,          "0"},
            '{31'd1,          "1"},
            '{31'd7,          "7"},
            '{31'd9,          "9"},
            '{31'd10,         "10"},
            '{31'd99,         "99"},
            '{31'd100,        "100"},
            '{31'd12345,      "12345"},
            '{31'd65535,      ""},
            '{31'd999999999,  "999999999"},
            '{31'd1000000000, "1000000000"},
            '{31'd1000000001, ""},
            '{31'd2147483647, "2147483647"},
            '{31'd1073741824, ""},
            '{31'd1431655765, ""},
            '{31'd715827882,  ""},
            '{31'd1999999999, ""},
            '{31'd2000000000, ""},
            '{31'd0,          "0"}
        };

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows back to back, no idling
        foreach (directed_rows[i]) begin
            queue_number(directed_rows[i].value, directed_rows[i].text);
        end
        wait_drained();

        // long receiver hold-off while the sender keeps offering, then idling phases
        hold_request = 1'b1;
        run_phase(0, 0, RANDOM_PER_PH);
        run_phase(83, 0, RANDOM_PER_PH);
        run_phase(0, 83, RANDOM_PER_PH);
        run_phase(33, 33, RANDOM_PER_PH);

        // nothing more may come out
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("converted %0d numbers (zero, every digit count, full range) into %0d digits",
                 numbers_accepted, digits_checked);
        $display("idling patterns: none, sender, receiver, both; %0d mismatches",
                 mismatch_count);
        if (mismatch_count == 0 && expected_digits.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+sv
sv/b2d_pkg.sv
sv/b2d_if.sv
sv/b2d_cell.sv
sv/b2d_chain.sv
sv/binary_to_decimal_ascii.sv
tb/binary_to_decimal_ascii_tb.sv
